// File: hdl/pmsc_pkg.sv
package pmsc_pkg;

  // Encoder tick counter width
  localparam int TICK_BITS = 16;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  // Field and register widths
  localparam int MODE_W    = 2;
  localparam int DUTY_IN_W = 7;
  localparam int DRIVE_W   = 23;
  localparam int ERR_OUT_W = 39;
  localparam int SPEED_W   = 22;
  localparam int GAIN_W    = 24;
  localparam int WIN_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Datapath widths
  localparam int MUL_IN_W = 25;
  localparam int ACC_W    = 2 * MUL_IN_W;
  localparam int REF_W    = 29;
  localparam int ERR_W    = 40;
  localparam int TERM_W   = 24;
  localparam int SUM_W    = 24;
  localparam int ADD_W    = SUM_W + 2;
  localparam int RPM_CALC_W = (TICK_BITS + 6 > SPEED_W) ? TICK_BITS + 6 : SPEED_W + 1;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CTRL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_WINDOW = 3'd3;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd655;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd16384;
  localparam logic [WIN_W-1:0]  WINDOW_RST     = 8'd101;

  // Q16.16 constants
  localparam logic [DUTY_IN_W-1:0] DUTY_LO = 7'd10;
  localparam logic [DUTY_IN_W-1:0] DUTY_HI = 7'd80;
  localparam logic [MUL_IN_W-1:0]  REF_SLOPE_Q = 25'd2677604;   // 40.857
  localparam logic [MUL_IN_W-1:0]  SCALE_Q     = 25'd63570;     // 0.97
  localparam logic [REF_W-1:0]     REF_BASE_Q  = 29'd163840000; // 2500
  localparam logic signed [ACC_W-1:0] TERM_POS  = 50'sd655360;   // +10
  localparam logic signed [ACC_W-1:0] TERM_NEG  = -50'sd655360;  // -10
  localparam logic signed [ACC_W-1:0] INTEG_POS = 50'sd1310720;  // +20
  localparam logic signed [ACC_W-1:0] INTEG_NEG = -50'sd1310720; // -20
  localparam logic [SUM_W-1:0]     DUTY_MAX = 24'd7864320;
  localparam logic [SPEED_W-1:0]   RPM_MAX  = 22'd4194303;

endpackage

// File: hdl/pmsc_chan_if.sv
interface pmsc_in_if;
  import pmsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [DUTY_IN_W-1:0] pot_duty;
  modport source (output valid, output mode, output pot_duty, input ready);
  modport sink   (input valid, input mode, input pot_duty, output ready);
endinterface

interface pmsc_out_if;
  import pmsc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [DRIVE_W-1:0]          drive_duty;
  logic signed [ERR_OUT_W-1:0] speed_error;
  logic [SPEED_W-1:0]          measured_speed;
  modport source (output valid, output drive_duty, output speed_error,
                  output measured_speed, input ready);
  modport sink   (input valid, input drive_duty, input speed_error,
                  input measured_speed, output ready);
endinterface

interface pmsc_cfg_if;
  import pmsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/pid_motor_speed_control_unit.sv
// Encoder-edge, timer-tick and unused-mode beats finish in the accept cycle.
// A control beat steps through the sequencer from ST_REF_MUL to ST_FIN; one 25x25 multiplier
// and one 26-bit adder are reused by the sequencer, 9 products per step.
// No new input beat is taken until the result of a control beat is loaded.
// Reset (rst_n low, synchronous): gains and window to defaults, counters,
// speed, integral and previous error to zero, no result pending.
module pid_motor_speed_control_unit (
  input  logic        clk,
  input  logic        rst_n,
  pmsc_in_if.sink     in_ch,
  pmsc_out_if.source  out_ch,
  pmsc_cfg_if.sink    cfg_ch
);
  import pmsc_pkg::*;

  // Sequencer: each state issues at most one multiply and consumes the
  // product issued in the cycle before (prod_r).
  // Q16.16 x gain products are split: x = hi*2^16 + lo, so
  // floor(x*g / 2^16) = hi*g + floor(lo*g / 2^16), exact and two 25x25 passes.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REF_MUL,  // (duty-10) * slope
    ST_REF_ADD,  // ref = product + base
    ST_SC_LO,    // ref low * 0.97
    ST_SC_HI,    // ref high * 0.97; take low part, minus rpm
    ST_ERR,      // error = partial + high product
    ST_P_LO,     // err low * Kp; error delta
    ST_P_HI,     // err high * Kp
    ST_I_LO,     // err low * Ki; clamp P term
    ST_I_HI,     // err high * Ki; sum = duty + P
    ST_D_LO,     // delta low * Kd; integral update
    ST_D_HI,     // delta high * Kd; sum += integral
    ST_D_SUM,    // clamp D term
    ST_FIN       // sum += D, saturate, load result
  } state_t;

  state_t state_r;

  // Configuration
  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] integ_gain_r;
  logic [GAIN_W-1:0] deriv_gain_r;
  logic [WIN_W-1:0]  speed_window_r;

  // Persistent state
  logic [TICK_BITS-1:0]     tick_count_r;
  logic [WIN_W-1:0]         window_count_r;
  logic [SPEED_W-1:0]       speed_rpm_r;
  logic signed [TERM_W-1:0] integral_r;
  logic signed [ERR_W-1:0]  prev_err_r;

  // Working registers
  logic [DUTY_IN_W-1:0]     duty_r;
  logic [REF_W-1:0]         ref_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  diff_r;
  logic signed [TERM_W-1:0] term_r;
  logic [SUM_W-1:0]         sum_r;

  // Result register
  logic                        out_valid_r;
  logic [DRIVE_W-1:0]          out_drive_r;
  logic signed [ERR_OUT_W-1:0] out_err_r;
  logic [SPEED_W-1:0]          out_speed_r;

  // Shared multiplier
  logic signed [MUL_IN_W-1:0] mul_a;
  logic signed [MUL_IN_W-1:0] mul_b;
  logic signed [ACC_W-1:0]    prod_nxt;

  // Shared adder for the duty sum
  logic signed [ADD_W-1:0] add_x;
  logic signed [ADD_W-1:0] add_y;
  logic signed [ADD_W-1:0] add_sum;
  logic [SUM_W-1:0]        sum_floor;
  logic [SUM_W-1:0]        sum_sat;

  logic signed [ACC_W-1:0]  low_part;
  logic signed [ACC_W-1:0]  hi_sum;
  logic signed [TERM_W-1:0] term_clamped;
  logic signed [TERM_W-1:0] integ_nxt;

  logic                  in_accept;
  logic [DUTY_IN_W-1:0]  duty_in;
  logic [WIN_W-1:0]      win_eff;
  logic [WIN_W:0]        win_next;
  logic [RPM_CALC_W-1:0] tick_ext;
  logic [RPM_CALC_W-1:0] rpm_calc;
  logic [SPEED_W-1:0]    rpm_sat;
  logic                  fin_load;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_accept    = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive_duty     = out_drive_r;
  assign out_ch.speed_error    = out_err_r;
  assign out_ch.measured_speed = out_speed_r;

  // Duty limited to 10..80
  assign duty_in = (in_ch.pot_duty < DUTY_LO) ? DUTY_LO :
                   (in_ch.pot_duty > DUTY_HI) ? DUTY_HI : in_ch.pot_duty;

  // Speed window; zero counts as one
  assign win_eff  = (speed_window_r == '0) ? WIN_W'(1) : speed_window_r;
  assign win_next = {1'b0, window_count_r} + (WIN_W + 1)'(1);

  // rpm = ticks * 60 as ticks*64 - ticks*4
  assign tick_ext = RPM_CALC_W'(tick_count_r);
  assign rpm_calc = (tick_ext << 6) - (tick_ext << 2);
  assign rpm_sat  = (rpm_calc > RPM_CALC_W'(RPM_MAX)) ? RPM_MAX : rpm_calc[SPEED_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_REF_MUL: begin
        mul_a = $signed({18'b0, duty_r - DUTY_LO});
        mul_b = $signed(REF_SLOPE_Q);
      end
      ST_SC_LO: begin
        mul_a = $signed({9'b0, ref_r[15:0]});
        mul_b = $signed(SCALE_Q);
      end
      ST_SC_HI: begin
        mul_a = $signed({12'b0, ref_r[REF_W-1:16]});
        mul_b = $signed(SCALE_Q);
      end
      ST_P_LO: begin
        mul_a = $signed({9'b0, err_r[15:0]});
        mul_b = $signed({1'b0, prop_gain_r});
      end
      ST_P_HI: begin
        mul_a = $signed({err_r[ERR_W-1], err_r[ERR_W-1:16]});
        mul_b = $signed({1'b0, prop_gain_r});
      end
      ST_I_LO: begin
        mul_a = $signed({9'b0, err_r[15:0]});
        mul_b = $signed({1'b0, integ_gain_r});
      end
      ST_I_HI: begin
        mul_a = $signed({err_r[ERR_W-1], err_r[ERR_W-1:16]});
        mul_b = $signed({1'b0, integ_gain_r});
      end
      ST_D_LO: begin
        mul_a = $signed({9'b0, diff_r[15:0]});
        mul_b = $signed({1'b0, deriv_gain_r});
      end
      ST_D_HI: begin
        mul_a = $signed({diff_r[ERR_W-1], diff_r[ERR_W-1:16]});
        mul_b = $signed({1'b0, deriv_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Low partial product is unsigned and below 2^40: keep bits above the point
  assign low_part = $signed({26'b0, prod_r[39:16]});
  assign hi_sum   = acc_r + prod_r;

  assign term_clamped = (hi_sum > TERM_POS) ? TERM_W'(TERM_POS) :
                        (hi_sum < TERM_NEG) ? TERM_W'(TERM_NEG) : hi_sum[TERM_W-1:0];
  // Integral drops back to zero once outside +-20
  assign integ_nxt = (hi_sum > INTEG_POS || hi_sum < INTEG_NEG) ? '0 : hi_sum[TERM_W-1:0];

  always_comb begin
    add_x = '0;
    add_y = '0;
    case (state_r)
      ST_I_HI: begin
        add_x = $signed({3'b0, duty_r, 16'b0});
        add_y = $signed({{2{term_r[TERM_W-1]}}, term_r});
      end
      ST_D_HI: begin
        add_x = $signed({2'b0, sum_r});
        add_y = $signed({{2{integral_r[TERM_W-1]}}, integral_r});
      end
      ST_FIN: begin
        add_x = $signed({2'b0, sum_r});
        add_y = $signed({{2{term_r[TERM_W-1]}}, term_r});
      end
      default: begin
        add_x = '0;
        add_y = '0;
      end
    endcase
  end

  assign add_sum   = add_x + add_y;
  assign sum_floor = add_sum[ADD_W-1] ? '0 : add_sum[SUM_W-1:0];
  assign sum_sat   = (sum_floor > DUTY_MAX) ? DUTY_MAX : sum_floor;

  // Result slot free or being drained this cycle
  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      prop_gain_r    <= PROP_GAIN_RST;
      integ_gain_r   <= INTEG_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      speed_window_r <= WINDOW_RST;
      tick_count_r   <= '0;
      window_count_r <= '0;
      speed_rpm_r    <= '0;
      integral_r     <= '0;
      prev_err_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_PROP_GAIN:    prop_gain_r    <= cfg_ch.data[GAIN_W-1:0];
          CFG_INTEG_GAIN:   integ_gain_r   <= cfg_ch.data[GAIN_W-1:0];
          CFG_DERIV_GAIN:   deriv_gain_r   <= cfg_ch.data[GAIN_W-1:0];
          CFG_SPEED_WINDOW: speed_window_r <= cfg_ch.data[WIN_W-1:0];
          default: ;
        endcase
      end

      // Drained with no new result behind it
      if (out_valid_r && out_ch.ready && !fin_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_ch.mode)
              MODE_EDGE: begin
                if (tick_count_r != TICK_MAX) begin
                  tick_count_r <= tick_count_r + TICK_BITS'(1);
                end
              end
              MODE_TICK: begin
                if (win_next >= {1'b0, win_eff}) begin
                  speed_rpm_r    <= rpm_sat;
                  tick_count_r   <= '0;
                  window_count_r <= '0;
                end else begin
                  window_count_r <= win_next[WIN_W-1:0];
                end
              end
              MODE_CTRL: begin
                duty_r  <= duty_in;
                state_r <= ST_REF_MUL;
              end
              default: ;
            endcase
          end
        end
        ST_REF_MUL: begin
          state_r <= ST_REF_ADD;
        end
        ST_REF_ADD: begin
          ref_r   <= prod_r[REF_W-1:0] + REF_BASE_Q;
          state_r <= ST_SC_LO;
        end
        ST_SC_LO: begin
          state_r <= ST_SC_HI;
        end
        ST_SC_HI: begin
          acc_r   <= low_part - $signed({12'b0, speed_rpm_r, 16'b0});
          state_r <= ST_ERR;
        end
        ST_ERR: begin
          err_r   <= hi_sum[ERR_W-1:0];
          state_r <= ST_P_LO;
        end
        ST_P_LO: begin
          diff_r  <= err_r - prev_err_r;
          state_r <= ST_P_HI;
        end
        ST_P_HI: begin
          acc_r   <= low_part;
          state_r <= ST_I_LO;
        end
        ST_I_LO: begin
          term_r  <= term_clamped;
          state_r <= ST_I_HI;
        end
        ST_I_HI: begin
          acc_r   <= low_part + $signed({{26{integral_r[TERM_W-1]}}, integral_r});
          sum_r   <= sum_floor;
          state_r <= ST_D_LO;
        end
        ST_D_LO: begin
          integral_r <= integ_nxt;
          state_r    <= ST_D_HI;
        end
        ST_D_HI: begin
          acc_r   <= low_part;
          sum_r   <= sum_floor;
          state_r <= ST_D_SUM;
        end
        ST_D_SUM: begin
          term_r  <= term_clamped;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Hold here while an earlier result still waits
          if (fin_load) begin
            out_valid_r <= 1'b1;
            out_drive_r <= sum_sat[DRIVE_W-1:0];
            out_err_r   <= err_r[ERR_OUT_W-1:0];
            out_speed_r <= speed_rpm_r;
            prev_err_r  <= err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/pid_speed_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, tracks the speed loop state and compares each
// drive result beat against the predicted one.
module pid_speed_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [pmsc_pkg::MODE_W-1:0]           in_mode,
  input  logic [pmsc_pkg::DUTY_IN_W-1:0]        in_pot_duty,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [pmsc_pkg::DRIVE_W-1:0]          out_drive_duty,
  input  logic signed [pmsc_pkg::ERR_OUT_W-1:0] out_speed_error,
  input  logic [pmsc_pkg::SPEED_W-1:0]          out_measured_speed,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    mismatches,
  output int                                    outstanding
);
  import pmsc_pkg::*;

  localparam longint Q_ONE = 65536;

  typedef struct {
    logic [DRIVE_W-1:0]          drive_duty;
    logic signed [ERR_OUT_W-1:0] speed_error;
    logic [SPEED_W-1:0]          measured_speed;
  } drive_beat_t;

  drive_beat_t drive_q[$];

  logic [GAIN_W-1:0]    kp, ki, kd;
  logic [WIN_W-1:0]     window_len;
  logic [TICK_BITS-1:0] enc_ticks;
  logic [WIN_W-1:0]     win_ticks;
  logic [SPEED_W-1:0]   rpm_latched;
  longint               integ_acc;
  longint               last_err;

  function automatic longint clamp_term(longint x);
    if (x > longint'(TERM_POS)) return longint'(TERM_POS);
    if (x < longint'(TERM_NEG)) return longint'(TERM_NEG);
    return x;
  endfunction

  function automatic longint floor0(longint x);
    return (x < 0) ? 0 : x;
  endfunction

  // Advances the loop state by one accepted beat; control steps queue a result.
  task automatic track_beat(input logic [MODE_W-1:0] m, input logic [DUTY_IN_W-1:0] duty);
    longint      d, ref_speed, err, p_term, i_sum, d_term, acc;
    int unsigned win, next_win, rpm_calc;
    drive_beat_t want;
    case (m)
      MODE_EDGE: begin
        if (enc_ticks != TICK_MAX) enc_ticks++;
      end
      MODE_TICK: begin
        win = (window_len == 0) ? 1 : window_len;
        next_win = win_ticks + 1;
        if (next_win >= win) begin
          rpm_calc = enc_ticks * 60;
          rpm_latched = (rpm_calc > RPM_MAX) ? RPM_MAX : rpm_calc[SPEED_W-1:0];
          enc_ticks = '0;
          win_ticks = '0;
        end else begin
          win_ticks = next_win[WIN_W-1:0];
        end
      end
      MODE_CTRL: begin
        d = longint'(duty);
        if (d < longint'(DUTY_LO)) d = longint'(DUTY_LO);
        if (d > longint'(DUTY_HI)) d = longint'(DUTY_HI);
        ref_speed = (d - longint'(DUTY_LO)) * longint'(REF_SLOPE_Q) + longint'(REF_BASE_Q);
        err = ((ref_speed * longint'(SCALE_Q)) >>> 16) - longint'(rpm_latched) * Q_ONE;

        p_term = clamp_term((err * longint'(kp)) >>> 16);
        acc = floor0(d * Q_ONE + p_term);

        // integral drops back to zero once it leaves +-20
        i_sum = integ_acc + ((err * longint'(ki)) >>> 16);
        if (i_sum > longint'(INTEG_POS) || i_sum < longint'(INTEG_NEG)) i_sum = 0;
        integ_acc = i_sum;
        acc = floor0(acc + i_sum);

        d_term = clamp_term(((err - last_err) * longint'(kd)) >>> 16);
        acc = floor0(acc + d_term);
        if (acc > longint'(DUTY_MAX)) acc = longint'(DUTY_MAX);
        last_err = err;

        want.drive_duty     = acc[DRIVE_W-1:0];
        want.speed_error    = err[ERR_OUT_W-1:0];
        want.measured_speed = rpm_latched;
        drive_q.push_back(want);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst_n) begin
      kp          = PROP_GAIN_RST;
      ki          = INTEG_GAIN_RST;
      kd          = DERIV_GAIN_RST;
      window_len  = WINDOW_RST;
      enc_ticks   = '0;
      win_ticks   = '0;
      rpm_latched = '0;
      integ_acc   = 0;
      last_err    = 0;
      drive_q.delete();
      mismatches  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected drive beat duty %0d err %0d speed %0d", $realtime,
                     out_drive_duty, out_speed_error, out_measured_speed);
        end else begin
          want = drive_q.pop_front();
          if (out_drive_duty !== want.drive_duty || out_speed_error !== want.speed_error ||
              out_measured_speed !== want.measured_speed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: drive beat exp duty %0d err %0d speed %0d, got %0d %0d %0d",
                       $realtime, want.drive_duty, want.speed_error, want.measured_speed,
                       out_drive_duty, out_speed_error, out_measured_speed);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:    kp = cfg_data[GAIN_W-1:0];
          CFG_INTEG_GAIN:   ki = cfg_data[GAIN_W-1:0];
          CFG_DERIV_GAIN:   kd = cfg_data[GAIN_W-1:0];
          CFG_SPEED_WINDOW: window_len = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_beat(in_mode, in_pot_duty);
    end
    outstanding <= drive_q.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the motor speed PID. The checker instance does all
// prediction; this module only drives beats, paces the result side and waits.
module testbench;
  import pmsc_pkg::*;

  // mode 3 is not decoded by the block
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  // quiet margin that settle() waits once no result is outstanding
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 800;
  localparam int HOLD_AT_BEAT  = 40;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;

  // pacing state for the input side
  bit          tx_quiet;
  logic [WIN_W-1:0] cur_window;

  pmsc_in_if  in_ch ();
  pmsc_out_if out_ch ();
  pmsc_cfg_if cfg_ch ();

  pid_motor_speed_control_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pid_speed_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_mode            (in_ch.mode),
    .in_pot_duty        (in_ch.pot_duty),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_drive_duty     (out_ch.drive_duty),
    .out_speed_error    (out_ch.speed_error),
    .out_measured_speed (out_ch.measured_speed),
    .cfg_valid          (cfg_ch.valid),
    .cfg_ready          (cfg_ch.ready),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[pid_motor_speed_control_unit] ERROR");
    $finish;
  end

  // Result side: random stall per beat, with runs of zero stall, and one long
  // hold-off so the block backs up and stalls its input.
  initial begin
    int unsigned stall;
    int          taken;
    bit          rx_quiet;
    taken    = 0;
    rx_quiet = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (taken == HOLD_AT_BEAT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

  // One input beat; the random gap comes first, valid stays up across beats
  // when the gap is zero.
  task automatic send_beat(input logic [MODE_W-1:0] m, input logic [DUTY_IN_W-1:0] duty);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= m;
    in_ch.pot_duty <= duty;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every expected result, then let the block go idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers plus one index past the end of the map.
  task automatic load_regs(input logic [CFG_DATA_W-1:0] prop, input logic [CFG_DATA_W-1:0] integ,
                           input logic [CFG_DATA_W-1:0] deriv, input logic [CFG_DATA_W-1:0] win);
    logic [CFG_IDX_W-1:0]  idx  [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx[0] = CFG_PROP_GAIN;    vals[0] = prop;
    idx[1] = CFG_INTEG_GAIN;   vals[1] = integ;
    idx[2] = CFG_DERIV_GAIN;   vals[2] = deriv;
    idx[3] = CFG_SPEED_WINDOW; vals[3] = win;
    idx[4] = CFG_IDX_W'(CFG_SPEED_WINDOW + 1 + $urandom_range(0, 3));
    vals[4] = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= vals[k];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_window = win[WIN_W-1:0];
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 3))
      0:       return CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
      1:       return CFG_DATA_W'($urandom_range(0, 2000));
      2:       return CFG_DATA_W'($urandom_range(0, 70000));
      default: return CFG_DATA_W'($urandom_range(0, 300000));
    endcase
  endfunction

  function automatic logic [DUTY_IN_W-1:0] rand_duty();
    if ($urandom_range(0, 7) == 0) return DUTY_IN_W'($urandom_range(0, 127));
    return DUTY_IN_W'($urandom_range(DUTY_LO, DUTY_HI));
  endfunction

  // Mostly measurement cycles (edges, a closing window of ticks, a few control
  // steps) so the error lands near zero often; the rest is loose single beats.
  task automatic run_traffic(input int unsigned budget);
    int unsigned sent, n_edges, n_ticks, n_steps;
    logic [MODE_W-1:0] m;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        n_edges = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 95);
        n_ticks = (cur_window == 0) ? 1 : cur_window;
        if ($urandom_range(0, 7) == 0) n_ticks = $urandom_range(0, n_ticks + 1);
        n_steps = $urandom_range(1, 5);
        repeat (n_edges) send_beat(MODE_EDGE, DUTY_IN_W'($urandom_range(0, 127)));
        repeat (n_ticks) send_beat(MODE_TICK, DUTY_IN_W'($urandom_range(0, 127)));
        repeat (n_steps) send_beat(MODE_CTRL, rand_duty());
        sent += n_edges + n_ticks + n_steps;
      end else begin
        m = MODE_W'($urandom_range(0, 3));
        send_beat(m, DUTY_IN_W'($urandom_range(0, 127)));
        if (m != MODE_SPARE) sent++;
      end
    end
  endtask

  initial begin
    tx_quiet   = 1'b0;
    cur_window = WINDOW_RST;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_EDGE;
    in_ch.pot_duty  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_PROP_GAIN;
    cfg_ch.data     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: duty at both ends and out of range, small latched speed,
    // unused mode, a latch of an empty window.
    load_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, 24'd1);
    send_beat(MODE_CTRL, DUTY_LO);
    send_beat(MODE_CTRL, DUTY_HI);
    send_beat(MODE_CTRL, 7'd0);
    send_beat(MODE_CTRL, 7'd127);
    send_beat(MODE_CTRL, 7'd9);
    send_beat(MODE_CTRL, 7'd81);
    repeat (3) send_beat(MODE_EDGE, 7'd0);
    send_beat(MODE_TICK, 7'd0);
    send_beat(MODE_CTRL, 7'd45);
    send_beat(MODE_SPARE, 7'd127);
    send_beat(MODE_CTRL, 7'd45);
    send_beat(MODE_TICK, 7'd127);
    send_beat(MODE_CTRL, DUTY_LO);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: load_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, 24'd4);
        1: load_regs('0, '0, '0, {16'($urandom_range(0, 16'hFFFF)), 8'd0});
        2: load_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                     {16'($urandom_range(0, 16'hFFFF)), 8'd1});
        3: load_regs(rand_gain(), rand_gain(), rand_gain(), 24'd255);
        default: load_regs(rand_gain(), rand_gain(), rand_gain(),
                           {16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(1, 8))});
      endcase
      run_traffic((ph == 3) ? 450 : 180);
    end
    settle();

    if (mismatches == 0) begin
      $display("[pid_motor_speed_control_unit] OK");
    end else begin
      $display("[pid_motor_speed_control_unit] ERROR");
    end
    $finish;
  end

endmodule
